FILE: design/shk_pkg.sv
// Shared types and codes for the session handshake and keepalive block.
package shk_pkg;

    localparam logic [2:0] OP_TICK       = 3'd0;
    localparam logic [2:0] OP_RX_SYN     = 3'd1;
    localparam logic [2:0] OP_RX_ACK     = 3'd2;
    localparam logic [2:0] OP_RX_HB      = 3'd3;
    localparam logic [2:0] OP_CONNECT    = 3'd4;
    localparam logic [2:0] OP_DISCONNECT = 3'd5;

    localparam logic [1:0] ST_DISC = 2'd0;
    localparam logic [1:0] ST_CONN = 2'd1;
    localparam logic [1:0] ST_UP   = 2'd2;

    localparam logic [1:0] CAUSE_NONE       = 2'd0;
    localparam logic [1:0] CAUSE_CONNECT_TO = 2'd1;
    localparam logic [1:0] CAUSE_HB_TO      = 2'd2;
    localparam logic [1:0] CAUSE_MANUAL     = 2'd3;

    localparam int          ADDR_BITS = 5;
    localparam logic [2:0] REG_ENABLE      = 3'd0;
    localparam logic [2:0] REG_PROBE_BASE  = 3'd1;
    localparam logic [2:0] REG_PROBE_MAX   = 3'd2;
    localparam logic [2:0] REG_CONNECT_TO  = 3'd3;
    localparam logic [2:0] REG_HB_TO       = 3'd4;
    localparam logic [2:0] REG_HB_INTERVAL = 3'd5;

    localparam logic [15:0] RST_PROBE_BASE  = 16'd4;
    localparam logic [15:0] RST_PROBE_MAX   = 16'd64;
    localparam logic [15:0] RST_CONNECT_TO  = 16'd300;
    localparam logic [15:0] RST_HB_TO       = 16'd180;
    localparam logic [15:0] RST_HB_INTERVAL = 16'd30;

    typedef struct packed {
        logic        enable;
        logic [15:0] probe_base_interval;
        logic [15:0] probe_max_interval;
        logic [15:0] connect_limit;
        logic [15:0] keepalive_limit;
        logic [15:0] heartbeat_send_interval;
    } cfg_t;

    typedef struct packed {
        logic [1:0] link_state;
        logic       send_syn;
        logic       send_ack;
        logic       send_heartbeat;
        logic       became_connected;
        logic [1:0] disconnect_cause;
        logic       ignored;
    } result_t;

endpackage

FILE: design/shk_cfg_regs.sv
// APB configuration register file for the session block.
module shk_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [shk_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output shk_pkg::cfg_t                  cfg
);

    shk_pkg::cfg_t cfg_reg;
    logic [2:0]    reg_index;
    logic          wr_en;

    assign reg_index = paddr[4:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable                  <= 1'b0;
            cfg_reg.probe_base_interval     <= shk_pkg::RST_PROBE_BASE;
            cfg_reg.probe_max_interval      <= shk_pkg::RST_PROBE_MAX;
            cfg_reg.connect_limit           <= shk_pkg::RST_CONNECT_TO;
            cfg_reg.keepalive_limit         <= shk_pkg::RST_HB_TO;
            cfg_reg.heartbeat_send_interval <= shk_pkg::RST_HB_INTERVAL;
        end
        else if (wr_en)
        begin
            case (reg_index)
                shk_pkg::REG_ENABLE:      cfg_reg.enable <= pwdata[0];
                shk_pkg::REG_PROBE_BASE:  cfg_reg.probe_base_interval <= pwdata[15:0];
                shk_pkg::REG_PROBE_MAX:   cfg_reg.probe_max_interval <= pwdata[15:0];
                shk_pkg::REG_CONNECT_TO:  cfg_reg.connect_limit <= pwdata[15:0];
                shk_pkg::REG_HB_TO:       cfg_reg.keepalive_limit <= pwdata[15:0];
                shk_pkg::REG_HB_INTERVAL: cfg_reg.heartbeat_send_interval <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            shk_pkg::REG_ENABLE:      prdata = {31'd0, cfg_reg.enable};
            shk_pkg::REG_PROBE_BASE:  prdata = {16'd0, cfg_reg.probe_base_interval};
            shk_pkg::REG_PROBE_MAX:   prdata = {16'd0, cfg_reg.probe_max_interval};
            shk_pkg::REG_CONNECT_TO:  prdata = {16'd0, cfg_reg.connect_limit};
            shk_pkg::REG_HB_TO:       prdata = {16'd0, cfg_reg.keepalive_limit};
            shk_pkg::REG_HB_INTERVAL: prdata = {16'd0, cfg_reg.heartbeat_send_interval};
            default:                  prdata = 32'd0;
        endcase
    end

endmodule

FILE: design/shk_session.sv
// Session state registers and the per-event next-state and result logic.
module shk_session #(
    parameter int TICK_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  shk_pkg::cfg_t        cfg,
    input  logic [2:0]           opcode,
    input  logic [TICK_BITS-1:0] tick_now,
    input  logic                 sender_ok,
    input  logic                 heartbeat_send_ok,
    output shk_pkg::result_t     result
);

    logic [1:0]           session_reg,  session_next;
    logic [TICK_BITS-1:0] cs_tick_reg,  cs_tick_next;
    logic                 cs_valid_reg, cs_valid_next;
    logic [TICK_BITS-1:0] np_tick_reg,  np_tick_next;
    logic                 np_valid_reg, np_valid_next;
    logic [15:0]          probe_int_reg, probe_int_next;
    logic [TICK_BITS-1:0] rx_tick_reg,  rx_tick_next;
    logic                 rx_valid_reg, rx_valid_next;
    logic [TICK_BITS-1:0] tx_tick_reg,  tx_tick_next;
    logic                 tx_valid_reg, tx_valid_next;
    logic                 hs_seen_reg,  hs_seen_next;

    logic [16:0]          probe_dbl;

    // deadline sum clamped at the top of the tick range
    function automatic logic [TICK_BITS-1:0] sat_add(input logic [TICK_BITS-1:0] a,
                                                     input logic [15:0] d);
        logic [TICK_BITS:0] s;
        s = {1'b0, a} + {{(TICK_BITS-15){1'b0}}, d};
        return s[TICK_BITS] ? {TICK_BITS{1'b1}} : s[TICK_BITS-1:0];
    endfunction

    assign probe_dbl = {probe_int_reg, 1'b0};

    always_comb
    begin
        session_next   = session_reg;
        cs_tick_next   = cs_tick_reg;
        cs_valid_next  = cs_valid_reg;
        np_tick_next   = np_tick_reg;
        np_valid_next  = np_valid_reg;
        probe_int_next = probe_int_reg;
        rx_tick_next   = rx_tick_reg;
        rx_valid_next  = rx_valid_reg;
        tx_tick_next   = tx_tick_reg;
        tx_valid_next  = tx_valid_reg;
        hs_seen_next   = hs_seen_reg;

        result.send_syn         = 1'b0;
        result.send_ack         = 1'b0;
        result.send_heartbeat   = 1'b0;
        result.became_connected = 1'b0;
        result.disconnect_cause = shk_pkg::CAUSE_NONE;
        result.ignored          = 1'b0;

        if (!cfg.enable)
        begin
            // nothing changes
        end
        else if (opcode inside {shk_pkg::OP_RX_SYN, shk_pkg::OP_RX_ACK, shk_pkg::OP_RX_HB}
                 && !sender_ok)
        begin
            result.ignored = 1'b1;
        end
        else
        begin
            case (opcode)
                shk_pkg::OP_RX_SYN:
                begin
                    result.send_ack = 1'b1;
                    if (session_reg == shk_pkg::ST_DISC)
                    begin
                        session_next  = shk_pkg::ST_CONN;
                        cs_tick_next  = tick_now;
                        cs_valid_next = 1'b1;
                        np_tick_next  = sat_add(tick_now, cfg.probe_base_interval);
                        np_valid_next = 1'b1;
                    end
                    hs_seen_next = 1'b1;
                end
                shk_pkg::OP_RX_ACK:
                begin
                    hs_seen_next = 1'b1;
                end
                shk_pkg::OP_RX_HB:
                begin
                    rx_tick_next  = tick_now;
                    rx_valid_next = 1'b1;
                    if (session_reg == shk_pkg::ST_CONN)
                        hs_seen_next = 1'b1;
                end
                shk_pkg::OP_CONNECT:
                begin
                    if (session_reg == shk_pkg::ST_DISC)
                    begin
                        session_next   = shk_pkg::ST_CONN;
                        cs_valid_next  = 1'b0;
                        np_valid_next  = 1'b0;
                        probe_int_next = cfg.probe_base_interval;
                        hs_seen_next   = 1'b0;
                    end
                end
                shk_pkg::OP_DISCONNECT:
                begin
                    if (session_reg != shk_pkg::ST_DISC)
                    begin
                        session_next   = shk_pkg::ST_DISC;
                        rx_valid_next  = 1'b0;
                        cs_valid_next  = 1'b0;
                        np_valid_next  = 1'b0;
                        probe_int_next = cfg.probe_base_interval;
                        tx_valid_next  = 1'b0;
                        hs_seen_next   = 1'b0;
                        result.disconnect_cause = shk_pkg::CAUSE_MANUAL;
                    end
                end
                shk_pkg::OP_TICK:
                begin
                    if (session_reg == shk_pkg::ST_CONN)
                    begin
                        if (!cs_valid_reg)
                        begin
                            cs_tick_next  = tick_now;
                            cs_valid_next = 1'b1;
                            np_tick_next  = tick_now;
                            np_valid_next = 1'b1;
                        end
                        if (!np_valid_next || tick_now >= np_tick_next)
                        begin
                            result.send_syn = 1'b1;
                            np_tick_next    = sat_add(tick_now, probe_int_reg);
                            np_valid_next   = 1'b1;
                            probe_int_next  = (probe_dbl < {1'b0, cfg.probe_max_interval})
                                            ? probe_dbl[15:0] : cfg.probe_max_interval;
                        end
                        if (hs_seen_reg)
                        begin
                            session_next   = shk_pkg::ST_UP;
                            result.became_connected = 1'b1;
                            rx_tick_next   = tick_now;
                            rx_valid_next  = 1'b1;
                            tx_tick_next   = tick_now;
                            tx_valid_next  = 1'b1;
                            probe_int_next = cfg.probe_base_interval;
                            hs_seen_next   = 1'b0;
                        end
                        else if (cs_valid_next &&
                                 tick_now > sat_add(cs_tick_next, cfg.connect_limit))
                        begin
                            session_next   = shk_pkg::ST_DISC;
                            rx_valid_next  = 1'b0;
                            cs_valid_next  = 1'b0;
                            np_valid_next  = 1'b0;
                            probe_int_next = cfg.probe_base_interval;
                            result.disconnect_cause = shk_pkg::CAUSE_CONNECT_TO;
                        end
                    end
                    // keepalive checks see the values set above in this same event
                    if (session_next == shk_pkg::ST_UP && rx_valid_next &&
                        tick_now > sat_add(rx_tick_next, cfg.keepalive_limit))
                    begin
                        session_next   = shk_pkg::ST_DISC;
                        rx_valid_next  = 1'b0;
                        cs_valid_next  = 1'b0;
                        np_valid_next  = 1'b0;
                        probe_int_next = cfg.probe_base_interval;
                        tx_valid_next  = 1'b0;
                        result.disconnect_cause = shk_pkg::CAUSE_HB_TO;
                    end
                    if (session_next == shk_pkg::ST_UP &&
                        (!tx_valid_next ||
                         tick_now >= sat_add(tx_tick_next, cfg.heartbeat_send_interval)))
                    begin
                        result.send_heartbeat = 1'b1;
                        if (heartbeat_send_ok)
                        begin
                            tx_tick_next  = tick_now;
                            tx_valid_next = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        result.link_state = session_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_reg   <= shk_pkg::ST_DISC;
            cs_tick_reg   <= '0;
            cs_valid_reg  <= 1'b0;
            np_tick_reg   <= '0;
            np_valid_reg  <= 1'b0;
            probe_int_reg <= shk_pkg::RST_PROBE_BASE;
            rx_tick_reg   <= '0;
            rx_valid_reg  <= 1'b0;
            tx_tick_reg   <= '0;
            tx_valid_reg  <= 1'b0;
            hs_seen_reg   <= 1'b0;
        end
        else if (step)
        begin
            session_reg   <= session_next;
            cs_tick_reg   <= cs_tick_next;
            cs_valid_reg  <= cs_valid_next;
            np_tick_reg   <= np_tick_next;
            np_valid_reg  <= np_valid_next;
            probe_int_reg <= probe_int_next;
            rx_tick_reg   <= rx_tick_next;
            rx_valid_reg  <= rx_valid_next;
            tx_tick_reg   <= tx_tick_next;
            tx_valid_reg  <= tx_valid_next;
            hs_seen_reg   <= hs_seen_next;
        end
    end

endmodule

FILE: design/session_handshake_keepalive.sv
// Session handshake/keepalive top level: input register, session logic, result register.
// Session state and result register load together when the held input event advances.
// Throughput: one event per cycle unless a full result register is not being taken.
// in_ready drops only while the result register is full and not being taken.
// Reset (rst_n low, asynchronous): session disconnected, all tick marks invalid,
// configuration registers return to their default values, both pipeline stages empty.
module session_handshake_keepalive #(
    parameter int TICK_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [shk_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [2:0]                     opcode,
    input  logic [TICK_BITS-1:0]           tick_now,
    input  logic                           sender_ok,
    input  logic                           heartbeat_send_ok,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     link_state,
    output logic                           send_syn,
    output logic                           send_ack,
    output logic                           send_heartbeat,
    output logic                           became_connected,
    output logic [1:0]                     disconnect_cause,
    output logic                           ignored
);

    shk_pkg::cfg_t        cfg;
    shk_pkg::result_t     core_result;
    shk_pkg::result_t     result_reg;
    logic                 out_valid_reg;
    logic                 in_valid_reg;
    logic [2:0]           opcode_reg;
    logic [TICK_BITS-1:0] tick_reg;
    logic                 sender_ok_reg;
    logic                 hb_ok_reg;
    logic                 advance;

    // held event moves into the result register when that register frees up
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    shk_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    shk_session #(
        .TICK_BITS (TICK_BITS)
    ) u_session (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (advance),
        .cfg               (cfg),
        .opcode            (opcode_reg),
        .tick_now          (tick_reg),
        .sender_ok         (sender_ok_reg),
        .heartbeat_send_ok (hb_ok_reg),
        .result            (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            opcode_reg    <= opcode;
            tick_reg      <= tick_now;
            sender_ok_reg <= sender_ok;
            hb_ok_reg     <= heartbeat_send_ok;
        end
        if (advance)
            result_reg <= core_result;
    end

    assign out_valid        = out_valid_reg;
    assign link_state       = result_reg.link_state;
    assign send_syn         = result_reg.send_syn;
    assign send_ack         = result_reg.send_ack;
    assign send_heartbeat   = result_reg.send_heartbeat;
    assign became_connected = result_reg.became_connected;
    assign disconnect_cause = result_reg.disconnect_cause;
    assign ignored          = result_reg.ignored;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for session_handshake_keepalive: directed table, then random traffic.
module tb;
    import shk_pkg::*;

    // opcodes the block has no meaning for
    localparam logic [2:0] OP_UNUSED_A = 3'd6;
    localparam logic [2:0] OP_UNUSED_B = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [2:0]           opcode = OP_TICK;
    logic [31:0]          tick_now = '0;
    logic                 sender_ok = 1'b0;
    logic                 heartbeat_send_ok = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [1:0]           link_state;
    logic                 send_syn;
    logic                 send_ack;
    logic                 send_heartbeat;
    logic                 became_connected;
    logic [1:0]           disconnect_cause;
    logic                 ignored;

    session_handshake_keepalive uut (.*);

    always #2 clk = ~clk;

    initial
    begin
        #2000000;
        $display("tb: errors");
        $finish;
    end

    // ---------------- session predictor ----------------
    cfg_t        regs_m;
    logic [1:0]  sess;
    logic [31:0] start_tick;
    logic        start_ok;
    logic [31:0] probe_tick;
    logic        probe_ok;
    logic [15:0] probe_gap;
    logic [31:0] rx_hb_tick;
    logic        rx_hb_ok;
    logic [31:0] tx_hb_tick;
    logic        tx_hb_ok;
    logic        shake_seen;

    function automatic void reset_model();
        regs_m.enable                  = 1'b0;
        regs_m.probe_base_interval     = RST_PROBE_BASE;
        regs_m.probe_max_interval      = RST_PROBE_MAX;
        regs_m.connect_limit           = RST_CONNECT_TO;
        regs_m.keepalive_limit         = RST_HB_TO;
        regs_m.heartbeat_send_interval = RST_HB_INTERVAL;
        sess       = ST_DISC;
        start_tick = '0;
        start_ok   = 1'b0;
        probe_tick = '0;
        probe_ok   = 1'b0;
        probe_gap  = RST_PROBE_BASE;
        rx_hb_tick = '0;
        rx_hb_ok   = 1'b0;
        tx_hb_tick = '0;
        tx_hb_ok   = 1'b0;
        shake_seen = 1'b0;
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_ENABLE:      regs_m.enable = val[0];
            REG_PROBE_BASE:  regs_m.probe_base_interval = val[15:0];
            REG_PROBE_MAX:   regs_m.probe_max_interval = val[15:0];
            REG_CONNECT_TO:  regs_m.connect_limit = val[15:0];
            REG_HB_TO:       regs_m.keepalive_limit = val[15:0];
            REG_HB_INTERVAL: regs_m.heartbeat_send_interval = val[15:0];
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] reg_value(logic [2:0] idx);
        case (idx)
            REG_ENABLE:      return {31'b0, regs_m.enable};
            REG_PROBE_BASE:  return {16'b0, regs_m.probe_base_interval};
            REG_PROBE_MAX:   return {16'b0, regs_m.probe_max_interval};
            REG_CONNECT_TO:  return {16'b0, regs_m.connect_limit};
            REG_HB_TO:       return {16'b0, regs_m.keepalive_limit};
            REG_HB_INTERVAL: return {16'b0, regs_m.heartbeat_send_interval};
            default:         return '0;
        endcase
    endfunction

    // deadlines clamp at the top of the tick range
    function automatic logic [31:0] deadline(logic [31:0] t, logic [15:0] d);
        logic [32:0] s;
        s = {1'b0, t} + {17'b0, d};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void drop_session();
        sess      = ST_DISC;
        rx_hb_ok  = 1'b0;
        start_ok  = 1'b0;
        probe_ok  = 1'b0;
        probe_gap = regs_m.probe_base_interval;
    endfunction

    function automatic result_t step_session(logic [2:0] op, logic [31:0] t, logic sok,
                                             logic hbok);
        result_t     r;
        logic [16:0] dbl;
        r = '0;
        if (regs_m.enable)
        begin
            if ((op == OP_RX_SYN || op == OP_RX_ACK || op == OP_RX_HB) && !sok)
                r.ignored = 1'b1;
            else
            begin
                case (op)
                    OP_RX_SYN:
                    begin
                        r.send_ack = 1'b1;
                        if (sess == ST_DISC)
                        begin
                            sess       = ST_CONN;
                            start_tick = t;
                            start_ok   = 1'b1;
                            probe_tick = deadline(t, regs_m.probe_base_interval);
                            probe_ok   = 1'b1;
                        end
                        shake_seen = 1'b1;
                    end
                    OP_RX_ACK: shake_seen = 1'b1;
                    OP_RX_HB:
                    begin
                        rx_hb_tick = t;
                        rx_hb_ok   = 1'b1;
                        if (sess == ST_CONN)
                            shake_seen = 1'b1;
                    end
                    OP_CONNECT:
                    begin
                        if (sess == ST_DISC)
                        begin
                            sess       = ST_CONN;
                            start_ok   = 1'b0;
                            probe_ok   = 1'b0;
                            probe_gap  = regs_m.probe_base_interval;
                            shake_seen = 1'b0;
                        end
                    end
                    OP_DISCONNECT:
                    begin
                        if (sess != ST_DISC)
                        begin
                            drop_session();
                            tx_hb_ok   = 1'b0;
                            shake_seen = 1'b0;
                            r.disconnect_cause = CAUSE_MANUAL;
                        end
                    end
                    OP_TICK:
                    begin
                        if (sess == ST_CONN)
                        begin
                            // first tick after a connect request starts the clock
                            if (!start_ok)
                            begin
                                start_tick = t;
                                start_ok   = 1'b1;
                                probe_tick = t;
                                probe_ok   = 1'b1;
                            end
                            if (!probe_ok || t >= probe_tick)
                            begin
                                dbl        = {probe_gap, 1'b0};
                                r.send_syn = 1'b1;
                                probe_tick = deadline(t, probe_gap);
                                probe_ok   = 1'b1;
                                probe_gap  = (dbl < {1'b0, regs_m.probe_max_interval}) ?
                                             dbl[15:0] : regs_m.probe_max_interval;
                            end
                            if (shake_seen)
                            begin
                                sess       = ST_UP;
                                r.became_connected = 1'b1;
                                rx_hb_tick = t;
                                rx_hb_ok   = 1'b1;
                                tx_hb_tick = t;
                                tx_hb_ok   = 1'b1;
                                probe_gap  = regs_m.probe_base_interval;
                                shake_seen = 1'b0;
                            end
                            else if (start_ok && t > deadline(start_tick, regs_m.connect_limit))
                            begin
                                drop_session();
                                r.disconnect_cause = CAUSE_CONNECT_TO;
                            end
                        end
                        if (sess == ST_UP && rx_hb_ok &&
                            t > deadline(rx_hb_tick, regs_m.keepalive_limit))
                        begin
                            drop_session();
                            tx_hb_ok = 1'b0;
                            r.disconnect_cause = CAUSE_HB_TO;
                        end
                        if (sess == ST_UP && (!tx_hb_ok ||
                            t >= deadline(tx_hb_tick, regs_m.heartbeat_send_interval)))
                        begin
                            r.send_heartbeat = 1'b1;
                            if (hbok)
                            begin
                                tx_hb_tick = t;
                                tx_hb_ok   = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
        r.link_state = sess;
        return r;
    endfunction

    // ---------------- result checking ----------------
    result_t     expected_q[$];
    int          errors = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_writes = 0;
    int          n_up = 0;
    int unsigned tx_max = 0;
    int unsigned rx_max = 0;
    int unsigned rx_wait = 0;
    int unsigned hold_req = 0;
    int unsigned hold_left = 0;
    logic [31:0] cur_tick = '0;

    task automatic check_field(string name, logic [1:0] want, logic [1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            rx_wait = (rx_max == 0) ? 0 : $urandom_range(0, rx_max);
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: result transaction with nothing expected, state %0d",
                         $time, link_state);
            end
            else
            begin
                want = expected_q.pop_front();
                n_checked++;
                if (became_connected === 1'b1)
                    n_up++;
                check_field("link_state", want.link_state, link_state);
                check_field("send_syn", {1'b0, want.send_syn}, {1'b0, send_syn});
                check_field("send_ack", {1'b0, want.send_ack}, {1'b0, send_ack});
                check_field("send_heartbeat", {1'b0, want.send_heartbeat},
                            {1'b0, send_heartbeat});
                check_field("became_connected", {1'b0, want.became_connected},
                            {1'b0, became_connected});
                check_field("disconnect_cause", want.disconnect_cause, disconnect_cause);
                check_field("ignored", {1'b0, want.ignored}, {1'b0, ignored});
            end
        end
    end

    // receiver: per-transaction stall, plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            out_ready = 1'b0;
            hold_left--;
        end
        else if (rx_wait != 0)
        begin
            out_ready = 1'b0;
            rx_wait--;
        end
        else
            out_ready = 1'b1;
    end

    // ---------------- stimulus ----------------
    task automatic drain_results();
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_event(logic [2:0] op, logic [31:0] t, logic sok, logic hbok,
                              bit typed, result_t want);
        int unsigned gap;
        result_t     pred;
        gap = (tx_max == 0) ? 0 : $urandom_range(0, tx_max);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        opcode            = op;
        tick_now          = t;
        sender_ok         = sok;
        heartbeat_send_ok = hbok;
        in_valid          = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pred = step_session(op, t, sok, hbok);
        expected_q.insert(expected_q.size(), typed ? want : pred);
        n_sent++;
        @(negedge clk);
    endtask

    // write while idle, then read the register back
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        in_valid = 1'b0;
        drain_results();
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        apply_reg(idx, val);
        n_writes++;
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== reg_value(idx))
        begin
            errors++;
            $display("%0t: readback of register %0d, expected %0h, got %0h",
                     $time, idx, reg_value(idx), prdata);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_timers(logic [15:0] base, logic [15:0] cap, logic [15:0] cto,
                              logic [15:0] hto, logic [15:0] hint);
        write_reg(REG_PROBE_BASE, {16'b0, base});
        write_reg(REG_PROBE_MAX, {16'b0, cap});
        write_reg(REG_CONNECT_TO, {16'b0, cto});
        write_reg(REG_HB_TO, {16'b0, hto});
        write_reg(REG_HB_INTERVAL, {16'b0, hint});
    endtask

    // mostly protocol-shaped events for the current state, with some noise
    function automatic logic [2:0] pick_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return (r < 2) ? OP_UNUSED_A : OP_UNUSED_B;
        r = $urandom_range(0, 99);
        case (sess)
            ST_DISC:
            begin
                if (r < 35) return OP_CONNECT;
                if (r < 45) return OP_RX_SYN;
                if (r < 50) return OP_DISCONNECT;
                if (r < 55) return OP_RX_ACK;
                if (r < 60) return OP_RX_HB;
                return OP_TICK;
            end
            ST_CONN:
            begin
                if (r < 20) return OP_RX_ACK;
                if (r < 28) return OP_RX_SYN;
                if (r < 38) return OP_RX_HB;
                if (r < 41) return OP_CONNECT;
                if (r < 45) return OP_DISCONNECT;
                return OP_TICK;
            end
            default:
            begin
                if (r < 25) return OP_RX_HB;
                if (r < 30) return OP_RX_SYN;
                if (r < 33) return OP_RX_ACK;
                if (r < 37) return OP_DISCONNECT;
                if (r < 40) return OP_CONNECT;
                return OP_TICK;
            end
        endcase
    endfunction

    task automatic run_traffic(int n, int unsigned step_max);
        logic [2:0] op;
        for (int i = 0; i < n; i++)
        begin
            op = pick_op();
            if ($urandom_range(0, 99) < 3)
                cur_tick = $urandom();
            else
                cur_tick = cur_tick + $urandom_range(0, step_max);
            send_event(op, cur_tick, $urandom_range(0, 9) != 0, $urandom_range(0, 4) != 0,
                       1'b0, '0);
        end
    endtask

    typedef struct {
        bit         is_cfg;
        logic [2:0] code;
        logic [31:0] arg;
        logic       sok;
        logic       hbok;
        bit         typed;
        result_t    want;
    } plan_row_t;

    plan_row_t plan[$];

    function automatic void add_row(plan_row_t p);
        plan.insert(plan.size(), p);
    endfunction

    function automatic result_t outcome(logic [1:0] st, logic syn, logic ack, logic hb,
                                        logic up, logic [1:0] cause, logic ign);
        result_t r;
        r.link_state       = st;
        r.send_syn         = syn;
        r.send_ack         = ack;
        r.send_heartbeat   = hb;
        r.became_connected = up;
        r.disconnect_cause = cause;
        r.ignored          = ign;
        return r;
    endfunction

    function automatic plan_row_t ev(logic [2:0] op, logic [31:0] t, logic sok, logic hbok,
                                     bit typed, result_t want);
        plan_row_t p;
        p.is_cfg = 1'b0;
        p.code   = op;
        p.arg    = t;
        p.sok    = sok;
        p.hbok   = hbok;
        p.typed  = typed;
        p.want   = want;
        return p;
    endfunction

    function automatic plan_row_t wr(logic [2:0] idx, logic [31:0] val);
        plan_row_t p;
        p = ev(idx, val, 1'b0, 1'b0, 1'b0, '0);
        p.is_cfg = 1'b1;
        return p;
    endfunction

    initial
    begin
        reset_model();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // disabled block, then the handshake, keepalive, both timeouts and the tick ceiling
        add_row(ev(OP_RX_SYN, 32'd0, 1, 1, 1,
                   outcome(ST_DISC, 0, 0, 0, 0, CAUSE_NONE, 0)));
        add_row(ev(OP_UNUSED_B, 32'hFFFF_FFFF, 1, 1, 1,
                   outcome(ST_DISC, 0, 0, 0, 0, CAUSE_NONE, 0)));
        add_row(wr(REG_ENABLE, 32'd1));
        add_row(ev(OP_UNUSED_A, 32'd5, 1, 1, 1,
                   outcome(ST_DISC, 0, 0, 0, 0, CAUSE_NONE, 0)));
        add_row(ev(OP_RX_ACK, 32'd5, 0, 1, 1,
                   outcome(ST_DISC, 0, 0, 0, 0, CAUSE_NONE, 1)));
        add_row(ev(OP_DISCONNECT, 32'd6, 1, 1, 1,
                   outcome(ST_DISC, 0, 0, 0, 0, CAUSE_NONE, 0)));
        add_row(ev(OP_CONNECT, 32'd10, 1, 1, 1,
                   outcome(ST_CONN, 0, 0, 0, 0, CAUSE_NONE, 0)));
        add_row(ev(OP_CONNECT, 32'd10, 1, 1, 1,
                   outcome(ST_CONN, 0, 0, 0, 0, CAUSE_NONE, 0)));
        add_row(ev(OP_TICK, 32'd10, 1, 1, 1,
                   outcome(ST_CONN, 1, 0, 0, 0, CAUSE_NONE, 0)));
        add_row(ev(OP_TICK, 32'd12, 1, 1, 0, '0));
        add_row(ev(OP_TICK, 32'd14, 1, 1, 0, '0));
        add_row(ev(OP_RX_ACK, 32'd15, 1, 1, 0, '0));
        add_row(ev(OP_TICK, 32'd16, 1, 1, 1,
                   outcome(ST_UP, 0, 0, 0, 1, CAUSE_NONE, 0)));
        add_row(ev(OP_TICK, 32'd46, 1, 1, 1,
                   outcome(ST_UP, 0, 0, 1, 0, CAUSE_NONE, 0)));
        add_row(ev(OP_RX_SYN, 32'd50, 1, 1, 1,
                   outcome(ST_UP, 0, 1, 0, 0, CAUSE_NONE, 0)));
        add_row(ev(OP_RX_HB, 32'd60, 1, 1, 0, '0));
        add_row(ev(OP_TICK, 32'd241, 1, 0, 1,
                   outcome(ST_DISC, 0, 0, 0, 0, CAUSE_HB_TO, 0)));
        add_row(ev(OP_CONNECT, 32'd300, 1, 1, 0, '0));
        add_row(ev(OP_TICK, 32'd300, 1, 1, 0, '0));
        add_row(ev(OP_TICK, 32'd601, 1, 1, 1,
                   outcome(ST_DISC, 1, 0, 0, 0, CAUSE_CONNECT_TO, 0)));
        add_row(ev(OP_RX_SYN, 32'd700, 1, 1, 0, '0));
        add_row(ev(OP_TICK, 32'd700, 1, 1, 0, '0));
        add_row(ev(OP_DISCONNECT, 32'd710, 1, 1, 1,
                   outcome(ST_DISC, 0, 0, 0, 0, CAUSE_MANUAL, 0)));
        add_row(ev(OP_RX_HB, 32'd720, 0, 0, 1,
                   outcome(ST_DISC, 0, 0, 0, 0, CAUSE_NONE, 1)));
        add_row(ev(OP_CONNECT, 32'hFFFF_FFF0, 1, 1, 0, '0));
        add_row(ev(OP_TICK, 32'hFFFF_FFFF, 1, 1, 0, '0));

        tx_max = 12;
        rx_max = 12;
        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_reg(plan[i].code, plan[i].arg);
            else
                send_event(plan[i].code, plan[i].arg, plan[i].sok, plan[i].hbok,
                           plan[i].typed, plan[i].want);
        end

        // short timers, full idling on both sides
        set_timers(16'd1, 16'd8, 16'd40, 16'd30, 16'd5);
        cur_tick = 32'd1000;
        run_traffic(90, 8);

        // zero timeouts and heartbeat interval; long receiver hold-off with a back-to-back sender, then a full drain
        set_timers(16'd2, 16'hFFFF, 16'd0, 16'd0, 16'd0);
        tx_max   = 0;
        rx_max   = 0;
        hold_req = 80;
        run_traffic(30, 3);
        in_valid = 1'b0;
        drain_results();
        run_traffic(30, 3);

        // full-range timers near the tick ceiling, so deadlines clamp
        set_timers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        tx_max   = 3;
        rx_max   = 3;
        cur_tick = 32'hFFFE_0000;
        run_traffic(60, 3000);

        // zero probe interval, cap of one
        set_timers(16'd0, 16'd1, 16'd20, 16'd12, 16'd3);
        tx_max   = 12;
        rx_max   = 0;
        cur_tick = 32'h0001_0000;
        run_traffic(60, 4);

        // disabled stretch: state must survive the enable toggle
        write_reg(REG_ENABLE, 32'd0);
        run_traffic(20, 4);
        write_reg(REG_ENABLE, 32'd1);

        // cap below the base interval
        set_timers(16'd5, 16'd3, 16'd100, 16'd50, 16'd10);
        tx_max   = 0;
        rx_max   = 12;
        cur_tick = 32'h8000_0000;
        run_traffic(120, 12);

        in_valid = 1'b0;
        for (int guard = 0; guard < 5000 && expected_q.size() != 0; guard++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (expected_q.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, expected_q.size());
        end
        $display("summary: %0d events sent, %0d results checked, %0d register writes",
                 n_sent, n_checked, n_writes);
        $display("summary: %0d connections made over six timer settings and a disabled stretch",
                 n_up);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
